### hdl/arps_pkg.sv
// ----------------------------------------------------------------------------
// arps_pkg
// Shared widths, register indexes and reset values for the axial rotation
// particle splitter.
// ----------------------------------------------------------------------------
package arps_pkg;

    localparam int POS_W    = 32;
    localparam int DIR_W    = 18;
    localparam int WGT_W    = 32;
    localparam int KIND_W   = 3;
    localparam int COUNT_W  = 7;
    localparam int STEP_W   = 18;
    localparam int SCALE_W  = 17;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_TYPE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_SCALE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_PREVIOUS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_NEXT     = 3'd6;

    localparam logic [COUNT_W-1:0]       RST_SPLIT_COUNT  = 7'd1;
    localparam logic [KIND_W-1:0]        RST_SPLIT_TYPE   = 3'd0;
    localparam logic signed [STEP_W-1:0] RST_STEP_COS     = 18'sd65536;
    localparam logic signed [STEP_W-1:0] RST_STEP_SIN     = 18'sd0;
    localparam logic [SCALE_W-1:0]       RST_WEIGHT_SCALE = 17'd65536;

    // route codes
    localparam logic ROUTE_PREV = 1'b0;
    localparam logic ROUTE_NEXT = 1'b1;

    // shared multiplier: 33-bit signed by 18-bit signed
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int RND_W   = ACC_W - 16;

    localparam int DIR_MAX = 65536;

endpackage

### hdl/axial_rotation_particle_splitter.sv
// ----------------------------------------------------------------------------
// axial_rotation_particle_splitter
// Routes particles by the sign of dir_z and splits one particle type into
// copies rotated step by step about the z axis.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one particle per transaction;
//   output channel out_valid/out_ready carries one result per transaction,
//   with last set on the final result of a particle.
//   Configuration registers are written through cfg_wr_en/cfg_index/cfg_data;
//   the user must write them only while the block is idle; the block does not enforce it.
//   Sequence: all arithmetic runs through one 33x18 multiplier and one
//   accumulator. A particle that is split first has its weight scaled
//   (S_WMUL, then S_WSAT), then each copy takes eight products plus
//   rounding; in_ready stays low until the last copy is loaded into the
//   result register. A passed-through particle holds in_ready low in
//   S_PASS until its result is loaded; a dropped one leaves the block idle.
//   The result register decouples the sides: the next copy is computed while
//   the previous one waits; if the receiver stalls, the sequencer waits at
//   the last step of the following copy.
//   Reset: configuration returns to its defaults, the sequencer goes idle and
//   the output register is emptied.
// ----------------------------------------------------------------------------
module axial_rotation_particle_splitter
    import arps_pkg::*;
#(
    parameter int MAX_SPLIT = 64
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [POS_W-1:0]      pos_x,
    input  logic signed [POS_W-1:0]      pos_y,
    input  logic signed [DIR_W-1:0]      dir_x,
    input  logic signed [DIR_W-1:0]      dir_y,
    input  logic signed [DIR_W-1:0]      dir_z,
    input  logic [KIND_W-1:0]            particle_kind,
    input  logic [WGT_W-1:0]             weight_in,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         route,
    output logic signed [POS_W-1:0]      pos_x_out,
    output logic signed [POS_W-1:0]      pos_y_out,
    output logic signed [DIR_W-1:0]      dir_x_out,
    output logic signed [DIR_W-1:0]      dir_y_out,
    output logic [WGT_W-1:0]             weight_out,
    output logic                         last
);

    localparam int CNT_W = $clog2(MAX_SPLIT + 1);
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    // step sequence within one copy
    localparam logic [3:0] PH_FIRST   = 4'd0;
    localparam logic [3:0] PH_X_DONE  = 4'd3;
    localparam logic [3:0] PH_Y_DONE  = 4'd5;
    localparam logic [3:0] PH_DX_DONE = 4'd7;
    localparam logic [3:0] PH_LAST    = 4'd9;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS,
        S_WMUL,
        S_WSAT,
        S_ROT
    } state_t;

    // configuration
    logic [COUNT_W-1:0]        split_count_reg;
    logic [KIND_W-1:0]         split_type_reg;
    logic signed [STEP_W-1:0]  step_cos_reg;
    logic signed [STEP_W-1:0]  step_sin_reg;
    logic [SCALE_W-1:0]        weight_scale_reg;
    logic                      has_previous_reg;
    logic                      has_next_reg;

    // control
    state_t                    state_reg;
    logic [3:0]                phase_reg;
    logic [CNT_W-1:0]          copy_cnt_reg;
    logic [CNT_W-1:0]          n_reg;
    logic                      out_valid_reg;

    // datapath
    logic signed [POS_W-1:0]   cur_px_reg;
    logic signed [POS_W-1:0]   cur_py_reg;
    logic signed [DIR_W-1:0]   cur_dx_reg;
    logic signed [DIR_W-1:0]   cur_dy_reg;
    logic [WGT_W-1:0]          held_w_reg;
    logic                      route_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    logic signed [POS_W-1:0]   pos_x_out_reg;
    logic signed [POS_W-1:0]   pos_y_out_reg;
    logic signed [DIR_W-1:0]   dir_x_out_reg;
    logic signed [DIR_W-1:0]   dir_y_out_reg;
    logic [WGT_W-1:0]          weight_out_reg;
    logic                      route_out_reg;
    logic                      last_out_reg;

    // combinational
    logic                      in_fire;
    logic                      out_free;
    logic                      load_pass;
    logic                      load_rot;
    logic                      last_copy;
    logic                      acc_en;
    logic                      is_split;
    logic [CNT_W-1:0]          n_eff;
    logic [CMP_W-1:0]          sc_ext;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_res;
    logic [3:0]                prod_idx;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [RND_W-1:0]   rnd_val;
    logic signed [POS_W-1:0]   rnd_pos;
    logic signed [DIR_W-1:0]   rnd_dir;
    logic [PROD_W-2:0]         w_sum;
    logic [WGT_W-1:0]          w_sat;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_count_reg  <= RST_SPLIT_COUNT;
            split_type_reg   <= RST_SPLIT_TYPE;
            step_cos_reg     <= RST_STEP_COS;
            step_sin_reg     <= RST_STEP_SIN;
            weight_scale_reg <= RST_WEIGHT_SCALE;
            has_previous_reg <= 1'b0;
            has_next_reg     <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_SPLIT_COUNT:  split_count_reg  <= cfg_data[COUNT_W-1:0];
                CFG_SPLIT_TYPE:   split_type_reg   <= cfg_data[KIND_W-1:0];
                CFG_STEP_COS:     step_cos_reg     <= $signed(cfg_data[STEP_W-1:0]);
                CFG_STEP_SIN:     step_sin_reg     <= $signed(cfg_data[STEP_W-1:0]);
                CFG_WEIGHT_SCALE: weight_scale_reg <= cfg_data[SCALE_W-1:0];
                CFG_HAS_PREVIOUS: has_previous_reg <= cfg_data[0];
                CFG_HAS_NEXT:     has_next_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // control decode
    // ------------------------------------------------------------------
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign load_pass = (state_reg == S_PASS) && out_free;
    assign load_rot  = (state_reg == S_ROT) && (phase_reg == PH_LAST) && out_free;
    assign last_copy = ((copy_cnt_reg + CNT_W'(1)) == n_reg);
    assign is_split  = (particle_kind == split_type_reg);

    // zero count means one copy; clip at MAX_SPLIT
    always_comb
    begin
        sc_ext = CMP_W'(split_count_reg);
        if (sc_ext == '0)
            n_eff = CNT_W'(1);
        else if (sc_ext > CMP_W'(MAX_SPLIT))
            n_eff = CNT_W'(MAX_SPLIT);
        else
            n_eff = CNT_W'(sc_ext);
    end

    // ------------------------------------------------------------------
    // shared multiplier
    // products per copy: 0 x*c, 1 y*s, 2 y*c, 3 x*s (pos, then dir at 4..7)
    // ------------------------------------------------------------------
    always_comb
    begin
        if (state_reg == S_WMUL)
        begin
            mul_a = $signed({1'b0, held_w_reg});
            mul_b = $signed({1'b0, weight_scale_reg});
        end
        else
        begin
            if (phase_reg[2])
                mul_a = (phase_reg[0] == phase_reg[1]) ? MUL_A_W'(cur_dx_reg)
                                                       : MUL_A_W'(cur_dy_reg);
            else
                mul_a = (phase_reg[0] == phase_reg[1]) ? MUL_A_W'(cur_px_reg)
                                                       : MUL_A_W'(cur_py_reg);
            mul_b = phase_reg[0] ? step_sin_reg : step_cos_reg;
        end
    end

    assign mul_res = mul_a * mul_b;

    // accumulate the product taken one step earlier
    assign prod_idx = phase_reg - 4'd1;
    assign prod_ext = ACC_W'(prod_reg);
    assign acc_en   = (phase_reg != PH_FIRST) && (phase_reg != PH_LAST);

    always_comb
    begin
        if (!prod_idx[0])
            acc_next = prod_ext;
        else if (prod_idx[1])
            acc_next = acc_reg - prod_ext;
        else
            acc_next = acc_reg + prod_ext;
    end

    // round to nearest, ties up: floor((acc + 2^15) / 2^16)
    assign acc_rnd = acc_reg + ACC_W'(32768);
    assign rnd_val = acc_rnd[ACC_W-1:16];

    always_comb
    begin
        if (rnd_val > RND_W'(signed'(33'sh0_7FFF_FFFF)))
            rnd_pos = {1'b0, {(POS_W-1){1'b1}}};
        else if (rnd_val < RND_W'(signed'(33'sh1_8000_0000)))
            rnd_pos = {1'b1, {(POS_W-1){1'b0}}};
        else
            rnd_pos = rnd_val[POS_W-1:0];

        if (rnd_val > RND_W'(DIR_MAX))
            rnd_dir = DIR_W'(DIR_MAX);
        else if (rnd_val < RND_W'(-DIR_MAX))
            rnd_dir = DIR_W'(-DIR_MAX);
        else
            rnd_dir = rnd_val[DIR_W-1:0];
    end

    // scaled weight, product is never negative
    assign w_sum = prod_reg[PROD_W-2:0] + (PROD_W-1)'(32768);
    assign w_sat = (|w_sum[PROD_W-2:WGT_W+16]) ? {WGT_W{1'b1}} : w_sum[WGT_W+15:16];

    // ------------------------------------------------------------------
    // sequencer and output valid
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_FIRST;
            copy_cnt_reg  <= '0;
            n_reg         <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_pass || load_rot)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (dir_z[DIR_W-1])
                        begin
                            if (has_previous_reg)
                                state_reg <= S_PASS;
                        end
                        else if ((dir_z != '0) && has_next_reg)
                        begin
                            if (is_split)
                            begin
                                state_reg    <= S_WMUL;
                                n_reg        <= n_eff;
                                copy_cnt_reg <= '0;
                                phase_reg    <= PH_FIRST;
                            end
                            else
                                state_reg <= S_PASS;
                        end
                    end
                end
                S_PASS:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                S_WMUL:
                    state_reg <= S_WSAT;
                S_WSAT:
                    state_reg <= S_ROT;
                S_ROT:
                begin
                    if (phase_reg != PH_LAST)
                        phase_reg <= phase_reg + 4'd1;
                    else if (out_free)
                    begin
                        phase_reg <= PH_FIRST;
                        if (last_copy)
                            state_reg <= S_IDLE;
                        else
                            copy_cnt_reg <= copy_cnt_reg + CNT_W'(1);
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_res;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cur_px_reg <= pos_x;
                    cur_py_reg <= pos_y;
                    cur_dx_reg <= dir_x;
                    cur_dy_reg <= dir_y;
                    held_w_reg <= weight_in;
                    route_reg  <= dir_z[DIR_W-1] ? ROUTE_PREV : ROUTE_NEXT;
                end
            end
            S_WSAT:
                held_w_reg <= w_sat;
            S_ROT:
            begin
                if (acc_en)
                    acc_reg <= acc_next;
                // in-place update: for x and dir_x the old value is consumed by the multiply
                // issued in this same step
                if (phase_reg == PH_X_DONE)
                    cur_px_reg <= rnd_pos;
                if (phase_reg == PH_Y_DONE)
                    cur_py_reg <= rnd_pos;
                if (phase_reg == PH_DX_DONE)
                    cur_dx_reg <= rnd_dir;
                if (load_rot)
                    cur_dy_reg <= rnd_dir;
            end
            default: ;
        endcase

        if (load_pass || load_rot)
        begin
            route_out_reg  <= route_reg;
            pos_x_out_reg  <= cur_px_reg;
            pos_y_out_reg  <= cur_py_reg;
            dir_x_out_reg  <= cur_dx_reg;
            dir_y_out_reg  <= load_rot ? rnd_dir : cur_dy_reg;
            weight_out_reg <= held_w_reg;
            last_out_reg   <= load_pass ? 1'b1 : last_copy;
        end
    end

    assign out_valid  = out_valid_reg;
    assign route      = route_out_reg;
    assign pos_x_out  = pos_x_out_reg;
    assign pos_y_out  = pos_y_out_reg;
    assign dir_x_out  = dir_x_out_reg;
    assign dir_y_out  = dir_y_out_reg;
    assign weight_out = weight_out_reg;
    assign last       = last_out_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_LAST)
        else $error("step counter out of range");

    a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROT) |-> (copy_cnt_reg < n_reg))
        else $error("copy counter passed split count");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROT) |-> (n_reg >= CNT_W'(1) && n_reg <= CNT_W'(MAX_SPLIT)))
        else $error("split count outside 1..MAX_SPLIT");

    a_final_copy: assert property (@(posedge clk) disable iff (!rst_n)
        (load_rot && last_copy) |=> (state_reg == S_IDLE && out_valid_reg && last_out_reg))
        else $error("final copy did not end the split");

    a_rot_route: assert property (@(posedge clk) disable iff (!rst_n)
        load_rot |=> (route_out_reg == ROUTE_NEXT))
        else $error("rotated copy sent backward");

endmodule

### tb/tb_axial_rotation_particle_splitter.sv
// ----------------------------------------------------------------------------
// tb_axial_rotation_particle_splitter
// Self-checking bench for the particle splitter. A directed table covers
// routing, dropped particles, register extremes and saturation. Randomized
// register settings and particles follow. Every result is checked field by
// field against a local fixed-point model of routing, weight scaling and
// stepwise z-axis rotation. Both handshakes see random stalls.
// ----------------------------------------------------------------------------
module tb_axial_rotation_particle_splitter;
    import arps_pkg::*;

    localparam int     SPLIT_LIMIT    = 64;
    localparam int     SETTLE_CYCLES  = 16;
    localparam int     LONG_HOLD      = 400;
    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     RANDOM_PHASES  = 10;
    localparam int     PHASE_ITEMS    = 31;
    localparam real    TWO_PI         = 6.283185307179586;
    localparam longint POS_HI         = 2147483647;
    localparam longint POS_LO         = -POS_HI - 1;

    typedef enum logic [1:0] {CHK_MODEL, CHK_DROP, CHK_PASS_PREV, CHK_PASS_NEXT} row_check_t;

    typedef struct {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic [KIND_W-1:0]       kind;
        logic [WGT_W-1:0]        weight;
    } particle_t;

    typedef struct {
        logic                    route;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic [WGT_W-1:0]        weight;
        logic                    last;
    } split_result_t;

    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        particle_t             part;
        row_check_t            chk;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic signed [POS_W-1:0] pos_x = '0;
    logic signed [POS_W-1:0] pos_y = '0;
    logic signed [DIR_W-1:0] dir_x = '0;
    logic signed [DIR_W-1:0] dir_y = '0;
    logic signed [DIR_W-1:0] dir_z = '0;
    logic [KIND_W-1:0]       particle_kind = '0;
    logic [WGT_W-1:0]        weight_in = '0;

    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    route;
    logic signed [POS_W-1:0] pos_x_out;
    logic signed [POS_W-1:0] pos_y_out;
    logic signed [DIR_W-1:0] dir_x_out;
    logic signed [DIR_W-1:0] dir_y_out;
    logic [WGT_W-1:0]        weight_out;
    logic                    last;

    // register shadow
    logic [COUNT_W-1:0]       cfg_count = RST_SPLIT_COUNT;
    logic [KIND_W-1:0]        cfg_type = RST_SPLIT_TYPE;
    logic signed [STEP_W-1:0] cfg_cos = RST_STEP_COS;
    logic signed [STEP_W-1:0] cfg_sin = RST_STEP_SIN;
    logic [SCALE_W-1:0]       cfg_scale = RST_WEIGHT_SCALE;
    logic                     cfg_has_prev = 1'b0;
    logic                     cfg_has_next = 1'b1;

    split_result_t awaited_particles[$];
    stim_row_t     directed_rows[$];
    int            mismatches = 0;
    int            quiet_cycles = 0;
    bit            sender_burst = 1'b0;
    bit            long_hold_req = 1'b0;

    axial_rotation_particle_splitter #(
        .MAX_SPLIT (SPLIT_LIMIT)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .dir_x         (dir_x),
        .dir_y         (dir_y),
        .dir_z         (dir_z),
        .particle_kind (particle_kind),
        .weight_in     (weight_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .route         (route),
        .pos_x_out     (pos_x_out),
        .pos_y_out     (pos_y_out),
        .dir_x_out     (dir_x_out),
        .dir_y_out     (dir_y_out),
        .weight_out    (weight_out),
        .last          (last)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // fixed-point helpers and model
    // ------------------------------------------------------------------------
    function automatic longint q16_round(longint acc);
        return (acc + 32768) >>> 16;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic split_result_t unchanged_copy(particle_t p, logic rt);
        split_result_t r;
        r.route  = rt;
        r.pos_x  = p.pos_x;
        r.pos_y  = p.pos_y;
        r.dir_x  = p.dir_x;
        r.dir_y  = p.dir_y;
        r.weight = p.weight;
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic void split_and_route(particle_t p);
        split_result_t r;
        int            copies;
        longint        c, s, px, py, dx, dy, nx, ny, scaled;
        if (p.dir_z < 0)
        begin
            if (cfg_has_prev)
                awaited_particles.push_back(unchanged_copy(p, ROUTE_PREV));
            return;
        end
        if (p.dir_z == 0 || !cfg_has_next)
            return;
        if (p.kind != cfg_type)
        begin
            awaited_particles.push_back(unchanged_copy(p, ROUTE_NEXT));
            return;
        end
        if (cfg_count == 0)
            copies = 1;
        else if (int'(cfg_count) > SPLIT_LIMIT)
            copies = SPLIT_LIMIT;
        else
            copies = int'(cfg_count);
        scaled = (longint'(p.weight) * longint'(cfg_scale) + 32768) >>> 16;
        r.route  = ROUTE_NEXT;
        r.weight = (scaled > 64'sh0_FFFF_FFFF) ? '1 : WGT_W'(scaled);
        c  = cfg_cos;
        s  = cfg_sin;
        px = p.pos_x;
        py = p.pos_y;
        dx = p.dir_x;
        dy = p.dir_y;
        // each copy rotates the previous one
        for (int i = 0; i < copies; i++)
        begin
            nx = clip(q16_round(px * c + py * s), POS_LO, POS_HI);
            ny = clip(q16_round(py * c - px * s), POS_LO, POS_HI);
            px = nx;
            py = ny;
            nx = clip(q16_round(dx * c + dy * s), -longint'(DIR_MAX), longint'(DIR_MAX));
            ny = clip(q16_round(dy * c - dx * s), -longint'(DIR_MAX), longint'(DIR_MAX));
            dx = nx;
            dy = ny;
            r.pos_x = POS_W'(px);
            r.pos_y = POS_W'(py);
            r.dir_x = DIR_W'(dx);
            r.dir_y = DIR_W'(dy);
            r.last  = (i == copies - 1);
            awaited_particles.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void add_item(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
                                     logic signed [DIR_W-1:0] dx, logic signed [DIR_W-1:0] dy,
                                     logic signed [DIR_W-1:0] dz, logic [KIND_W-1:0] kd,
                                     logic [WGT_W-1:0] w, row_check_t chk);
        stim_row_t row;
        row.is_write    = 1'b0;
        row.reg_idx     = '0;
        row.reg_val     = '0;
        row.part.pos_x  = px;
        row.part.pos_y  = py;
        row.part.dir_x  = dx;
        row.part.dir_y  = dy;
        row.part.dir_z  = dz;
        row.part.kind   = kd;
        row.part.weight = w;
        row.chk         = chk;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        stim_row_t row;
        row.part     = '{default: '0};
        row.is_write = 1'b1;
        row.reg_idx  = idx;
        row.reg_val  = val;
        row.chk      = CHK_DROP;
        directed_rows.push_back(row);
    endfunction

    function automatic logic signed [POS_W-1:0] rand_pos();
        int v;
        case ($urandom_range(0, 7))
            0: return POS_W'(POS_HI);
            1: return POS_W'(POS_LO);
            2, 3:
            begin
                v = int'($urandom_range(0, 2097152)) - 1048576;
                return POS_W'(v);
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [DIR_W-1:0] rand_dir();
        int v;
        case ($urandom_range(0, 7))
            0: v = DIR_MAX;
            1: v = -DIR_MAX;
            default: v = int'($urandom_range(0, 131072)) - DIR_MAX;
        endcase
        return DIR_W'(v);
    endfunction

    function automatic particle_t random_particle();
        particle_t p;
        int        dz;
        p.pos_x = rand_pos();
        p.pos_y = rand_pos();
        p.dir_x = rand_dir();
        p.dir_y = rand_dir();
        case ($urandom_range(0, 9))
            0: dz = 0;
            1, 2, 3: dz = -int'($urandom_range(1, DIR_MAX));
            default: dz = int'($urandom_range(1, DIR_MAX));
        endcase
        p.dir_z = DIR_W'(dz);
        // mostly the split type, so that rotation sequences dominate
        p.kind = ($urandom_range(0, 9) < 6) ? cfg_type : KIND_W'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
            0: p.weight = '0;
            1: p.weight = '1;
            default: p.weight = $urandom;
        endcase
        return p;
    endfunction

    function automatic int sender_gap();
        if (sender_burst)
            return 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 0;
            9: return int'($urandom_range(10, 40));
            default: return int'($urandom_range(1, 3));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_SPLIT_COUNT:  cfg_count    = val[COUNT_W-1:0];
            CFG_SPLIT_TYPE:   cfg_type     = val[KIND_W-1:0];
            CFG_STEP_COS:     cfg_cos      = val;
            CFG_STEP_SIN:     cfg_sin      = val;
            CFG_WEIGHT_SCALE: cfg_scale    = val[SCALE_W-1:0];
            CFG_HAS_PREVIOUS: cfg_has_prev = val[0];
            CFG_HAS_NEXT:     cfg_has_next = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // dropped particles leave nothing to wait for, so always let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (awaited_particles.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_setting(input bit force_next);
        int  n, n_eff, cos_v, sin_v, scale_v;
        real ang;
        case ($urandom_range(0, 9))
            0: n = 0;
            1: n = int'($urandom_range(SPLIT_LIMIT + 1, 127));
            2: n = SPLIT_LIMIT;
            default: n = int'($urandom_range(1, 16));
        endcase
        n_eff = (n == 0) ? 1 : ((n > SPLIT_LIMIT) ? SPLIT_LIMIT : n);
        ang = TWO_PI / n_eff;
        if ($urandom_range(0, 7) == 0)
        begin
            cos_v = int'($urandom_range(0, 262143));
            sin_v = int'($urandom_range(0, 262143));
        end
        else
        begin
            cos_v = int'($cos(ang) * 65536.0);
            sin_v = int'($sin(ang) * 65536.0);
        end
        case ($urandom_range(0, 7))
            0: scale_v = 0;
            1: scale_v = 131071;
            2: scale_v = 65536;
            default: scale_v = int'(65536.0 / n_eff);
        endcase
        write_reg(CFG_SPLIT_COUNT, CFG_DATA_W'(n));
        write_reg(CFG_SPLIT_TYPE, CFG_DATA_W'($urandom_range(0, 7)));
        write_reg(CFG_STEP_COS, CFG_DATA_W'(cos_v));
        write_reg(CFG_STEP_SIN, CFG_DATA_W'(sin_v));
        write_reg(CFG_WEIGHT_SCALE, CFG_DATA_W'(scale_v));
        write_reg(CFG_HAS_PREVIOUS, CFG_DATA_W'($urandom_range(0, 1)));
        write_reg(CFG_HAS_NEXT,
                  CFG_DATA_W'(force_next || ($urandom_range(0, 6) != 0)));
    endtask

    task automatic send_particle(input particle_t p, input row_check_t chk, input int gap);
        in_valid      <= 1'b1;
        pos_x         <= p.pos_x;
        pos_y         <= p.pos_y;
        dir_x         <= p.dir_x;
        dir_y         <= p.dir_y;
        dir_z         <= p.dir_z;
        particle_kind <= p.kind;
        weight_in     <= p.weight;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        case (chk)
            CHK_MODEL:     split_and_route(p);
            CHK_PASS_PREV: awaited_particles.push_back(unchanged_copy(p, ROUTE_PREV));
            CHK_PASS_NEXT: awaited_particles.push_back(unchanged_copy(p, ROUTE_NEXT));
            default: ;
        endcase
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        split_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_particles.size() == 0)
            begin
                $display("%0t: result with none expected, expected nothing, actual x=%0d y=%0d",
                         $time, pos_x_out, pos_y_out);
                mismatches++;
            end
            else
            begin
                want = awaited_particles.pop_front();
                check_field("route", want.route, route);
                check_field("pos_x_out", want.pos_x, pos_x_out);
                check_field("pos_y_out", want.pos_y, pos_y_out);
                check_field("dir_x_out", want.dir_x, dir_x_out);
                check_field("dir_y_out", want.dir_y, dir_y_out);
                check_field("weight_out", want.weight, weight_out);
                check_field("last", want.last, last);
            end
        end
    end

    // receiver stalls; free_flow gives stretches with no stall at all
    always @(posedge clk)
    begin
        int hold_cycles;
        bit free_flow;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_cycles = 0;
            free_flow = 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 149) == 0)
                free_flow = !free_flow;
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_cycles = LONG_HOLD;
                out_ready <= 1'b0;
            end
            else if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else if (!free_flow && $urandom_range(0, 3) == 0)
            begin
                hold_cycles = ($urandom_range(0, 4) == 0) ? int'($urandom_range(8, 30))
                                                          : int'($urandom_range(0, 2));
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int phase;
        // reset defaults: split type 0 with identity step passes through unchanged
        add_item(POS_W'(POS_HI), POS_W'(POS_LO), 18'sd65536, -18'sd65536, 18'sd1, 3'd0,
                 32'hFFFF_FFFF, CHK_PASS_NEXT);
        add_item(POS_W'(POS_LO), POS_W'(POS_HI), -18'sd65536, 18'sd65536, -18'sd65536, 3'd0,
                 32'h0, CHK_DROP);
        add_item(32'sd123, -32'sd456, 18'sd1000, -18'sd1000, 18'sd0, 3'd0, 32'd777, CHK_DROP);
        add_item(32'sd0, 32'sd0, 18'sd0, 18'sd0, 18'sd65536, 3'd5, 32'h0, CHK_PASS_NEXT);
        add_write(CFG_HAS_PREVIOUS, 18'd1);
        add_item(POS_W'(POS_LO), POS_W'(POS_HI), -18'sd65536, 18'sd65536, -18'sd1, 3'd7,
                 32'hFFFF_FFFF, CHK_PASS_PREV);
        add_write(CFG_HAS_NEXT, 18'd0);
        add_item(32'sh0001_0000, 32'sh0002_0000, 18'sd46341, 18'sd46341, 18'sd65536, 3'd0,
                 32'h0001_0000, CHK_DROP);
        add_item(-32'sd5, 32'sd5, 18'sd0, -18'sd65536, -18'sd3, 3'd0, 32'd1, CHK_PASS_PREV);
        // 45 degree step, eight copies
        add_write(CFG_HAS_NEXT, 18'd1);
        add_write(CFG_SPLIT_COUNT, 18'd8);
        add_write(CFG_SPLIT_TYPE, 18'd3);
        add_write(CFG_STEP_COS, 18'd46341);
        add_write(CFG_STEP_SIN, 18'd46341);
        add_write(CFG_WEIGHT_SCALE, 18'd8192);
        add_item(32'sh000A_0000, -32'sh0003_0000, 18'sd30000, -18'sd40000, 18'sd20000, 3'd3,
                 32'h0008_0000, CHK_MODEL);
        add_item(32'sh000A_0000, -32'sh0003_0000, 18'sd30000, -18'sd40000, 18'sd20000, 3'd2,
                 32'h0008_0000, CHK_PASS_NEXT);
        add_item(POS_W'(POS_HI), POS_W'(POS_HI), 18'sd65536, 18'sd65536, 18'sd1, 3'd3,
                 32'hFFFF_FFFF, CHK_MODEL);
        add_item(POS_W'(POS_LO), POS_W'(POS_LO), -18'sd65536, -18'sd65536, 18'sd65536, 3'd3,
                 32'd1, CHK_MODEL);
        // zero count acts as one, oversized count clips to the maximum
        add_write(CFG_SPLIT_COUNT, 18'd0);
        add_item(32'sh0007_0000, 32'sh0001_0000, 18'sd65536, 18'sd0, 18'sd5, 3'd3,
                 32'h0064_0000, CHK_MODEL);
        add_write(CFG_SPLIT_COUNT, 18'd127);
        add_item(32'sh0001_0000, 32'sd0, 18'sd0, 18'sd65536, 18'sd5, 3'd3,
                 32'h1234_5678, CHK_MODEL);
        // out-of-range step and scale saturate the results
        add_write(CFG_STEP_COS, 18'h1FFFF);
        add_write(CFG_STEP_SIN, 18'h20000);
        add_write(CFG_WEIGHT_SCALE, 18'h1FFFF);
        add_write(CFG_SPLIT_COUNT, 18'd3);
        add_item(32'sd1000, -32'sd1000, 18'sd65536, -18'sd65536, 18'sd9, 3'd3,
                 32'hFFFF_FFFF, CHK_MODEL);
        add_item(POS_W'(POS_HI), POS_W'(POS_LO), 18'sd0, 18'sd0, 18'sd9, 3'd3,
                 32'h0001_0000, CHK_MODEL);
        add_write(CFG_STEP_COS, 18'h30000);
        add_write(CFG_STEP_SIN, 18'h10000);
        add_write(CFG_WEIGHT_SCALE, 18'd0);
        add_write(CFG_SPLIT_COUNT, 18'd64);
        add_item(32'sh0003_0000, 32'sh0004_0000, 18'sd1, -18'sd1, 18'sd65536, 3'd3,
                 32'hFFFF_FFFF, CHK_MODEL);
        add_item(32'sh0003_0000, 32'sh0004_0000, 18'sd1, -18'sd1, -18'sd65536, 3'd3,
                 32'd5, CHK_PASS_PREV);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_write)
            begin
                wait_idle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end
            else
                send_particle(directed_rows[i].part, directed_rows[i].chk, sender_gap());
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            random_setting(phase == 1);
            // phase 1: receiver holds off while the sender keeps offering
            sender_burst = (phase == 1) || ($urandom_range(0, 3) == 0);
            if (phase == 1)
                long_hold_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_particle(random_particle(), CHK_MODEL, sender_gap());
        end

        wait_idle();
        if (mismatches == 0 && awaited_particles.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
hdl/arps_pkg.sv
hdl/axial_rotation_particle_splitter.sv
tb/tb_axial_rotation_particle_splitter.sv
